// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the packetizer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== sv/adtsrtp_pkg.sv =====
// ----------------------------------------------------------------------------
// adtsrtp_pkg
// Types and constants for the ADTS frame to RTP descriptor packetizer.
// ----------------------------------------------------------------------------
`default_nettype none

package adtsrtp_pkg;

  // Fixed sizes
  localparam int HEADER_BYTES = 12;
  localparam int MAX_RESULTS  = 6;
  localparam int CNT_W        = 3;
  localparam int LEN_W        = 13;
  localparam int CHUNK_W      = 14;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_TYPE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_SEQUENCE = 2'd1;

  // Reset values and header constants
  localparam logic [6:0]       PT_RESET    = 7'd98;
  localparam logic [15:0]      SEQ_RESET   = 16'd0;
  localparam logic [3:0]       HDR_NO_CRC  = 4'd7;
  localparam logic [3:0]       HDR_CRC     = 4'd9;
  localparam logic [1:0]       RTP_VERSION = 2'b10;

  typedef struct packed {
    logic [7:0]  adts_byte_one;
    logic [7:0]  adts_byte_three;
    logic [7:0]  adts_byte_four;
    logic [7:0]  adts_byte_five;
    logic [31:0] presentation_time;
  } in_t;

  typedef struct packed {
    logic [31:0] header_word;
    logic [31:0] time_stamp;
    logic [12:0] payload_offset;
    logic [10:0] payload_length;
    logic        last_packet;
    logic        malformed;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    logic load;      // capture a new frame header
    logic emit;      // write the next descriptor to the output register
    logic cap_last;  // this descriptor is the final allowed one
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last_chunk;  // remaining payload fits one packet, or frame is short
    logic slot_free;   // output register can take a descriptor
  } sts_t;

endpackage

`default_nettype wire

// ===== sv/adtsrtp_ctrl.sv =====
// ----------------------------------------------------------------------------
// adtsrtp_ctrl
// Sequencer: accepts one frame, then steps one descriptor per free slot.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module adtsrtp_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  adtsrtp_pkg::sts_t       sts,
  output adtsrtp_pkg::cmd_t       cmd
);
  import adtsrtp_pkg::*;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EMIT
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] count;
  logic             final_desc;

  // Decode commands from the current state
  always_comb begin
    in_ready     = (state == ST_IDLE) && !rst;
    cmd.load     = in_ready && in_valid;
    cmd.emit     = (state == ST_EMIT) && sts.slot_free;
    cmd.cap_last = (count == CNT_W'(MAX_RESULTS - 1));
    final_desc   = sts.last_chunk || cmd.cap_last;
  end

  // Hold state and descriptor count
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (cmd.load) begin
            state <= ST_EMIT;
            count <= '0;
          end
        end
        ST_EMIT: begin
          if (cmd.emit) begin
            if (final_desc) begin
              state <= ST_IDLE;
            end else begin
              count <= count + CNT_W'(1);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_CLK(a_count_range, count < CNT_W'(MAX_RESULTS), "descriptor count out of range")
  `ASSERT_NEVER(a_load_during_emit, cmd.load && cmd.emit, "load and emit together")
  `ASSERT_CLK(a_final_returns_idle, cmd.emit && final_desc |=> in_ready,
              "sequencer did not return to idle after final descriptor")

endmodule

`default_nettype wire

// ===== sv/adtsrtp_dp.sv =====
// ----------------------------------------------------------------------------
// adtsrtp_dp
// Datapath: frame length decode, chunk split, sequence counter, output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module adtsrtp_dp #(
  parameter int MTU_BYTES = 1400
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  adtsrtp_pkg::in_t                         in_data,
  input  adtsrtp_pkg::cmd_t                        cmd,
  output adtsrtp_pkg::sts_t                        sts,
  input  wire logic                                cfg_we,
  input  wire logic [adtsrtp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [adtsrtp_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output adtsrtp_pkg::out_t                        out_data
);
  import adtsrtp_pkg::*;

  localparam logic [CHUNK_W-1:0] CHUNK_MAX = CHUNK_W'(MTU_BYTES - HEADER_BYTES);

  logic [6:0]       ptype;
  logic [15:0]      seq;
  logic [15:0]      seq_next;
  logic [31:0]      ts;
  logic [LEN_W-1:0] left;
  logic [LEN_W-1:0] offset;
  logic             short_frame;

  logic [LEN_W-1:0] frame_len;
  logic [3:0]       hdr_size;
  logic             fits;
  logic [LEN_W-1:0] take;
  logic             last;

  // Decode the frame length and header size
  always_comb begin
    frame_len = {in_data.adts_byte_three[1:0], in_data.adts_byte_four,
                 in_data.adts_byte_five[7:5]};
    hdr_size  = in_data.adts_byte_one[0] ? HDR_NO_CRC : HDR_CRC;
  end

  // Size the next chunk
  always_comb begin
    fits      = ({1'b0, left} <= CHUNK_MAX);
    take      = fits ? left : CHUNK_MAX[LEN_W-1:0];
    last      = short_frame || fits || cmd.cap_last;
    seq_next  = seq + 16'd1;
    sts.last_chunk = short_frame || fits;
    sts.slot_free  = !out_valid || out_ready;
  end

  // Capture frame, advance chunk state and sequence counter
  always_ff @(posedge clk) begin
    if (rst) begin
      ptype <= PT_RESET;
      seq   <= SEQ_RESET;
    end else begin
      if (cfg_we && cfg_index == REG_PAYLOAD_TYPE) begin
        ptype <= cfg_data[6:0];
      end
      if (cfg_we && cfg_index == REG_START_SEQUENCE) begin
        seq <= cfg_data[15:0];
      end else if (cmd.emit && !short_frame) begin
        seq <= seq_next;
      end
    end
    if (cmd.load) begin
      ts          <= in_data.presentation_time;
      short_frame <= frame_len < LEN_W'(hdr_size);
      left        <= frame_len - LEN_W'(hdr_size);
      offset      <= LEN_W'(hdr_size);
    end else if (cmd.emit) begin
      left   <= left - take;
      offset <= offset + take;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.emit) begin
      if (short_frame) begin
        out_data <= '{header_word: '0, time_stamp: '0, payload_offset: '0,
                      payload_length: '0, last_packet: 1'b1, malformed: 1'b1};
      end else begin
        out_data.header_word    <= {RTP_VERSION, 1'b0, 1'b0, 4'd0, last, ptype, seq_next};
        out_data.time_stamp     <= ts;
        out_data.payload_offset <= offset;
        out_data.payload_length <= take[10:0];
        out_data.last_packet    <= last;
        out_data.malformed      <= 1'b0;
      end
    end
  end

  `ASSERT_CLK(a_seq_step, cmd.emit && !short_frame && !cfg_we |=> seq == $past(seq_next),
              "sequence counter did not advance by one")
  `ASSERT_CLK(a_malformed_last, out_valid && out_data.malformed |-> out_data.last_packet &&
              out_data.header_word == 32'd0, "malformed result not final or not cleared")
  `ASSERT_NEVER(a_emit_when_busy, cmd.emit && out_valid && !out_ready,
                "descriptor written over a pending result")

endmodule

`default_nettype wire

// ===== sv/adts_frame_rtp_packetizer.sv =====
// The frame is captured when it is accepted; its descriptors then pass through
// the output register one per cycle while the receiver takes them, 1 to 6 per
// frame. The input is ready again once the frame's final descriptor is written.
// The input waits while the sequencer steps through the frame's chunks.
// Reset: payload type 98, sequence counter 0, no result pending.
// ----------------------------------------------------------------------------
// adts_frame_rtp_packetizer
// Splits an AAC ADTS frame into RTP packet descriptors.
// ----------------------------------------------------------------------------
`default_nettype none

module adts_frame_rtp_packetizer #(
  parameter int MTU_BYTES = 1400
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  adtsrtp_pkg::in_t                         in_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output adtsrtp_pkg::out_t                        out_data,
  input  wire logic                                cfg_we,
  input  wire logic [adtsrtp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [adtsrtp_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import adtsrtp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  adtsrtp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath
  adtsrtp_dp #(
    .MTU_BYTES (MTU_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ADTS to RTP descriptor packetizer. Frames are
// offered on the input channel. A predictor running alongside works out the
// descriptor list of each accepted frame: chunk split, header word, sequence
// numbers and the malformed flag. Every descriptor the block returns is
// checked field by field against the oldest prediction. Both channels idle at
// random, and one long output hold-off forces the block to stall its input.
// ----------------------------------------------------------------------------

module tb_top;
  import adtsrtp_pkg::*;

  localparam int MTU_BYTES    = 1400;
  localparam int CHUNK_MAX    = MTU_BYTES - HEADER_BYTES;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int RANDOM_ITEMS = 100;

  // Indexes past the register list; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_t in_data;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Predictor state
  logic [6:0] rtp_payload_type;
  logic [15:0] rtp_sequence;
  out_t expected_packets[$];
  out_t want_packet;

  int mismatch_count = 0;
  int cycle_count = 0;
  bit quiet = 1'b0;
  int hold_asked = 0;
  int hold_served = 0;
  int hold_left = 0;

  adts_frame_rtp_packetizer #(
    .MTU_BYTES(MTU_BYTES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Build the descriptor list for one frame and advance the sequence counter
  function automatic void predict_packets(input in_t frame);
    logic [12:0] flen;
    int hdr;
    int raw;
    int done;
    int take;
    int count;
    logic last;
    out_t pkt;
    flen = {frame.adts_byte_three[1:0], frame.adts_byte_four, frame.adts_byte_five[7:5]};
    hdr = frame.adts_byte_one[0] ? int'(HDR_NO_CRC) : int'(HDR_CRC);
    if (int'(flen) < hdr) begin
      pkt = '0;
      pkt.last_packet = 1'b1;
      pkt.malformed = 1'b1;
      expected_packets.push_back(pkt);
      return;
    end
    raw = int'(flen) - hdr;
    done = 0;
    count = 0;
    last = 1'b0;
    while (!last) begin
      take = raw - done;
      if (take > CHUNK_MAX) begin
        take = CHUNK_MAX;
      end else begin
        last = 1'b1;
      end
      if (count == MAX_RESULTS - 1) begin
        last = 1'b1;
      end
      rtp_sequence = rtp_sequence + 16'd1;
      pkt.header_word = {RTP_VERSION, 6'b0, last, rtp_payload_type, rtp_sequence};
      pkt.time_stamp = frame.presentation_time;
      pkt.payload_offset = 13'(hdr + done);
      pkt.payload_length = 11'(take);
      pkt.last_packet = last;
      pkt.malformed = 1'b0;
      expected_packets.push_back(pkt);
      count++;
      done += take;
    end
  endfunction

  // Frame with the given CRC choice and length; bits that do not matter are random
  function automatic in_t adts_frame(input logic no_crc, input int flen,
                                     input logic [31:0] pts);
    logic [12:0] l;
    in_t frame;
    l = 13'(flen);
    frame.adts_byte_one = {7'($urandom), no_crc};
    frame.adts_byte_three = {6'($urandom), l[12:11]};
    frame.adts_byte_four = l[10:3];
    frame.adts_byte_five = {l[2:0], 5'($urandom)};
    frame.presentation_time = pts;
    return frame;
  endfunction

  // Mostly well-formed frames around the chunk boundaries, some pure noise
  function automatic in_t random_frame();
    int pick;
    logic no_crc;
    int hdr;
    int flen;
    in_t frame;
    pick = $urandom_range(0, 99);
    no_crc = 1'($urandom);
    hdr = no_crc ? int'(HDR_NO_CRC) : int'(HDR_CRC);
    if (pick < 10) begin
      flen = $urandom_range(0, 10);
    end else if (pick < 25) begin
      flen = $urandom_range(1, 5) * CHUNK_MAX + hdr + $urandom_range(0, 2) - 1;
    end else if (pick < 40) begin
      flen = $urandom_range(CHUNK_MAX + 10, 8191);
    end else if (pick < 88) begin
      flen = $urandom_range(7, MTU_BYTES);
    end else begin
      frame = in_t'({$urandom, $urandom});
      return frame;
    end
    return adts_frame(no_crc, flen, $urandom);
  endfunction

  function automatic bit sender_idles();
    return !quiet && ($urandom_range(0, 99) < 19);
  endfunction

  // Offer one frame; valid stays high after the transfer until the next call
  task automatic send_frame(input in_t frame);
    @(negedge clk);
    while (sender_idles()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= frame;
    do begin
      @(posedge clk);
    end while (!in_ready);
    predict_packets(frame);
  endtask

  // Drop valid and wait until every predicted descriptor has come back
  task automatic settle_frames();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_packets.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      REG_PAYLOAD_TYPE: rtp_payload_type = value[6:0];
      REG_START_SEQUENCE: rtp_sequence = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_payload_type(input logic [6:0] pt);
    write_reg(REG_PAYLOAD_TYPE, {9'($urandom), pt});
  endtask

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mismatch on %s: expected %h, got %h", what, want, got);
    end
  endtask

  // Receiver: random stalls, plus a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_served != hold_asked) begin
      hold_served = hold_asked;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet || ($urandom_range(0, 99) >= 19);
    end
  end

  // Compare each transfer with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_packets.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("descriptor with none expected: %h", out_data);
        end
      end else begin
        want_packet = expected_packets.pop_front();
        if (out_data.header_word !== want_packet.header_word)
          note_mismatch("header_word", want_packet.header_word, out_data.header_word);
        if (out_data.time_stamp !== want_packet.time_stamp)
          note_mismatch("time_stamp", want_packet.time_stamp, out_data.time_stamp);
        if (out_data.payload_offset !== want_packet.payload_offset)
          note_mismatch("payload_offset", 32'(want_packet.payload_offset),
                        32'(out_data.payload_offset));
        if (out_data.payload_length !== want_packet.payload_length)
          note_mismatch("payload_length", 32'(want_packet.payload_length),
                        32'(out_data.payload_length));
        if (out_data.last_packet !== want_packet.last_packet)
          note_mismatch("last_packet", 32'(want_packet.last_packet),
                        32'(out_data.last_packet));
        if (out_data.malformed !== want_packet.malformed)
          note_mismatch("malformed", 32'(want_packet.malformed), 32'(out_data.malformed));
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  // Reset values: payload type 98, sequence starting from zero
  task automatic test_reset_values();
    send_frame(adts_frame(1'b0, 100, $urandom));
    send_frame(adts_frame(1'b1, 7, $urandom));
    send_frame(adts_frame(1'b1, 5, $urandom));
    settle_frames();
  endtask

  // Short and empty frames, exact chunk fills and the largest frame
  task automatic test_special_frames();
    write_payload_type(7'd127);
    write_reg(REG_START_SEQUENCE, 16'h0000);
    send_frame(adts_frame(1'b0, 0, $urandom));
    send_frame(adts_frame(1'b1, 6, $urandom));
    send_frame(adts_frame(1'b0, 8, $urandom));
    send_frame(adts_frame(1'b1, 7, $urandom));
    send_frame(adts_frame(1'b0, 9, $urandom));
    send_frame(adts_frame(1'b1, 8, $urandom));
    send_frame(adts_frame(1'b1, 7 + CHUNK_MAX, $urandom));
    send_frame(adts_frame(1'b0, 9 + CHUNK_MAX, $urandom));
    send_frame(adts_frame(1'b1, 8 + CHUNK_MAX, $urandom));
    send_frame(adts_frame(1'b0, 8 + CHUNK_MAX, $urandom));
    send_frame(adts_frame(1'b1, 7 + 2 * CHUNK_MAX, $urandom));
    send_frame(adts_frame(1'b1, 7 + 5 * CHUNK_MAX, $urandom));
    send_frame(adts_frame(1'b1, 8191, 32'hFFFF_FFFF));
    send_frame(adts_frame(1'b0, 8191, 32'h0000_0000));
    send_frame(in_t'('1));
    send_frame(in_t'('0));
    settle_frames();
  endtask

  // Sequence counter wraps through zero inside one frame
  task automatic test_sequence_wrap();
    write_payload_type(7'd0);
    write_reg(REG_START_SEQUENCE, 16'hFFFC);
    send_frame(adts_frame(1'b0, 8191, $urandom));
    send_frame(adts_frame(1'b1, 3000, $urandom));
    settle_frames();
  endtask

  // Writes past the register list leave type and sequence untouched
  task automatic test_spare_registers();
    write_reg(REG_SPARE_A, 16'($urandom));
    write_reg(REG_SPARE_B, 16'($urandom));
    repeat (3) send_frame(random_frame());
    settle_frames();
  endtask

  // Hold the output long enough that the block fills and stalls its input
  task automatic test_input_stall();
    quiet = 1'b1;
    hold_asked++;
    repeat (30) send_frame(adts_frame(1'($urandom), $urandom_range(7, 8191), $urandom));
    settle_frames();
    quiet = 1'b0;
  endtask

  // Random frames over several register settings, one phase without gaps
  task automatic test_random_frames();
    logic [6:0] pt_set[4];
    logic [15:0] seq_set[4];
    pt_set = '{7'd0, 7'd127, 7'($urandom), 7'($urandom)};
    seq_set = '{16'hFFFF, 16'h0000, 16'($urandom), 16'($urandom)};
    for (int phase = 0; phase < 4; phase++) begin
      write_payload_type(pt_set[phase]);
      write_reg(REG_START_SEQUENCE, seq_set[phase]);
      quiet = (phase == 2);
      repeat (RANDOM_ITEMS) send_frame(random_frame());
      settle_frames();
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    rtp_payload_type = PT_RESET;
    rtp_sequence = SEQ_RESET;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_special_frames();
    test_sequence_wrap();
    test_spare_registers();
    test_input_stall();
    test_random_frames();

    mismatch_count += expected_packets.size();
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/adtsrtp_pkg.sv
sv/adtsrtp_ctrl.sv
sv/adtsrtp_dp.sv
sv/adts_frame_rtp_packetizer.sv
tb/sv/tb_top.sv
